### rtl/dftp_pkg.sv
package dftp_pkg;

    localparam int MAX_DIGITS_DEF     = 32;
    localparam int MAX_EXP_DIGITS_DEF = 5;

    localparam int CHAR_W  = 8;
    localparam int CNT_W   = 6;
    localparam int EXPC_W  = 3;
    localparam int ORDER_W = 18;
    localparam int OUT_W   = 32;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_E     = 8'h45;

    typedef struct packed {
        logic                      is_summary;
        logic [3:0]                digit_value;
        logic                      negative;
        logic [CNT_W-1:0]          digit_count;
        logic signed [ORDER_W-1:0] decimal_order;
        logic                      parse_error;
    } dftp_result_t;

    typedef struct packed {
        logic         digit_valid;
        logic         summary_valid;
        dftp_result_t digit;
        dftp_result_t summary;
    } dftp_push_t;

endpackage

### rtl/dftp_core.sv
module dftp_core #(
    parameter int MAX_DIGITS     = dftp_pkg::MAX_DIGITS_DEF,
    parameter int MAX_EXP_DIGITS = dftp_pkg::MAX_EXP_DIGITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [dftp_pkg::CHAR_W-1:0]   char_code,
    input  logic                          end_of_text,
    output dftp_pkg::dftp_push_t          push
);
    import dftp_pkg::*;

    localparam logic [2:0] PH_START      = 3'd0;
    localparam logic [2:0] PH_SIGNED     = 3'd1;
    localparam logic [2:0] PH_MANT       = 3'd2;
    localparam logic [2:0] PH_MANT_SPACE = 3'd3;
    localparam logic [2:0] PH_EXP_START  = 3'd4;
    localparam logic [2:0] PH_EXP_SPACE  = 3'd5;
    localparam logic [2:0] PH_EXP_DIGITS = 3'd6;

    localparam logic [CNT_W-1:0]  MAX_D = CNT_W'(MAX_DIGITS);
    localparam logic [EXPC_W-1:0] MAX_E = EXPC_W'(MAX_EXP_DIGITS);

    logic [2:0]         phase_reg,   phase_next;
    logic               sign_reg,    sign_next;
    logic               dot_reg,     dot_next;
    logic               nz_reg,      nz_next;
    logic [CNT_W-1:0]   raw_reg,     raw_next;
    logic [CNT_W-1:0]   sig_reg,     sig_next;
    logic [CNT_W-1:0]   frac_reg,    frac_next;
    logic [ORDER_W-1:0] exp_reg,     exp_next;
    logic               exp_neg_reg, exp_neg_next;
    logic [EXPC_W-1:0]  expc_reg,    expc_next;
    logic               err_reg,     err_next;

    logic               is_term;
    logic               is_digit;
    logic               is_sign;
    logic [3:0]         dval;
    logic               emit;
    logic               fin;
    logic               fin_err;
    logic [ORDER_W-1:0] exp_signed;
    logic [ORDER_W-1:0] order;

    assign is_term  = (char_code == CH_NUL) || (char_code == CH_LF);
    assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign is_sign  = (char_code == CH_PLUS) || (char_code == CH_MINUS);
    assign dval     = 4'(char_code - CH_ZERO);

    // character step
    always_comb
    begin
        phase_next   = phase_reg;
        sign_next    = sign_reg;
        dot_next     = dot_reg;
        nz_next      = nz_reg;
        raw_next     = raw_reg;
        sig_next     = sig_reg;
        frac_next    = frac_reg;
        exp_next     = exp_reg;
        exp_neg_next = exp_neg_reg;
        expc_next    = expc_reg;
        err_next     = err_reg;
        emit         = 1'b0;
        if (!is_term && !err_reg)
        begin
            if (phase_reg <= PH_MANT)
            begin
                priority if (is_digit)
                begin
                    if (raw_reg >= MAX_D)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_MANT;
                        raw_next   = raw_reg + 1'b1;
                        if (dot_reg)
                            frac_next = frac_reg + 1'b1;
                        if (nz_reg || dval != 4'd0)
                        begin
                            nz_next  = 1'b1;
                            sig_next = sig_reg + 1'b1;
                            emit     = 1'b1;
                        end
                    end
                end
                else if (char_code == CH_DOT && !dot_reg)
                begin
                    dot_next   = 1'b1;
                    phase_next = PH_MANT;
                end
                else if (phase_reg == PH_START && is_sign)
                begin
                    sign_next  = (char_code == CH_MINUS);
                    phase_next = PH_SIGNED;
                end
                else if (phase_reg == PH_SIGNED && char_code == CH_SPACE)
                begin
                    phase_next = PH_MANT;
                end
                else if (phase_reg == PH_MANT && char_code == CH_SPACE)
                begin
                    phase_next = PH_MANT_SPACE;
                end
                else if (phase_reg == PH_MANT && char_code == CH_E)
                begin
                    phase_next = PH_EXP_START;
                end
                else
                begin
                    err_next = 1'b1;
                end
            end
            else if (phase_reg == PH_MANT_SPACE)
            begin
                if (char_code == CH_E)
                    phase_next = PH_EXP_START;
                else
                    err_next = 1'b1;
            end
            else
            begin
                priority if (phase_reg == PH_EXP_START && char_code == CH_SPACE)
                begin
                    phase_next = PH_EXP_SPACE;
                end
                else if ((phase_reg == PH_EXP_START || phase_reg == PH_EXP_SPACE)
                         && is_sign)
                begin
                    exp_neg_next = (char_code == CH_MINUS);
                    phase_next   = PH_EXP_DIGITS;
                end
                else if (is_digit)
                begin
                    if (expc_reg >= MAX_E)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        expc_next  = expc_reg + 1'b1;
                        exp_next   = (exp_reg << 3) + (exp_reg << 1)
                                     + ORDER_W'(dval);
                        phase_next = PH_EXP_DIGITS;
                    end
                end
                else
                begin
                    err_next = 1'b1;
                end
            end
        end
    end

    assign fin        = is_term || end_of_text;
    assign fin_err    = err_next || (raw_next == '0);
    assign exp_signed = exp_neg_next ? (ORDER_W'(0) - exp_next) : exp_next;
    assign order      = exp_signed + ORDER_W'(sig_next) - ORDER_W'(frac_next);

    always_comb
    begin
        push.digit_valid           = accept && emit;
        push.summary_valid         = accept && fin;
        push.digit.is_summary      = 1'b0;
        push.digit.digit_value     = dval;
        push.digit.negative        = 1'b0;
        push.digit.digit_count     = '0;
        push.digit.decimal_order   = '0;
        push.digit.parse_error     = 1'b0;
        push.summary.is_summary    = 1'b1;
        push.summary.digit_value   = 4'd0;
        push.summary.negative      = 1'b0;
        push.summary.digit_count   = '0;
        push.summary.decimal_order = '0;
        push.summary.parse_error   = 1'b0;
        priority if (fin_err)
        begin
            push.summary.parse_error = 1'b1;
        end
        else if (sig_next == '0)
        begin
            push.summary.negative = sign_next;
        end
        else
        begin
            push.summary.negative      = sign_next;
            push.summary.digit_count   = sig_next;
            push.summary.decimal_order = order;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            sign_reg    <= 1'b0;
            dot_reg     <= 1'b0;
            nz_reg      <= 1'b0;
            raw_reg     <= '0;
            sig_reg     <= '0;
            frac_reg    <= '0;
            exp_reg     <= '0;
            exp_neg_reg <= 1'b0;
            expc_reg    <= '0;
            err_reg     <= 1'b0;
        end
        else if (accept)
        begin
            if (fin)
            begin
                phase_reg   <= PH_START;
                sign_reg    <= 1'b0;
                dot_reg     <= 1'b0;
                nz_reg      <= 1'b0;
                raw_reg     <= '0;
                sig_reg     <= '0;
                frac_reg    <= '0;
                exp_reg     <= '0;
                exp_neg_reg <= 1'b0;
                expc_reg    <= '0;
                err_reg     <= 1'b0;
            end
            else
            begin
                phase_reg   <= phase_next;
                sign_reg    <= sign_next;
                dot_reg     <= dot_next;
                nz_reg      <= nz_next;
                raw_reg     <= raw_next;
                sig_reg     <= sig_next;
                frac_reg    <= frac_next;
                exp_reg     <= exp_next;
                exp_neg_reg <= exp_neg_next;
                expc_reg    <= expc_next;
                err_reg     <= err_next;
            end
        end
    end

endmodule

### rtl/decimal_float_text_parser.sv
// A result word is queued when its input word is taken; m_axis shows the queue head.
// Throughput: one input word per cycle while the queue holds two words or fewer; a word
// that yields a digit and a summary pushes both into a four-entry output queue.
// Reset: rst_n asynchronous, active low; clears parse state and empties the queue.
module decimal_float_text_parser #(
    parameter int MAX_DIGITS     = dftp_pkg::MAX_DIGITS_DEF,
    parameter int MAX_EXP_DIGITS = dftp_pkg::MAX_EXP_DIGITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [dftp_pkg::CHAR_W-1:0]  s_axis_tdata,   // [7:0] char_code
    input  logic                         s_axis_tlast,   // end_of_text
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [3:0] digit_value, [4] negative, [10:5] digit_count,
    // [28:11] decimal_order, [29] parse_error, [31:30] zero
    output logic [dftp_pkg::OUT_W-1:0]   m_axis_tdata,
    output logic                         m_axis_tlast    // is_summary
);
    import dftp_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    dftp_push_t   push;
    dftp_result_t mem [DEPTH];
    dftp_result_t first_w;
    dftp_result_t head;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg,  count_next;
    logic             accept;
    logic             pop;
    logic [1:0]       n_push;

    assign s_axis_tready = (count_reg <= (PTR_W+1)'(DEPTH - 2));
    assign accept        = s_axis_tvalid && s_axis_tready;

    dftp_core #(
        .MAX_DIGITS     (MAX_DIGITS),
        .MAX_EXP_DIGITS (MAX_EXP_DIGITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .char_code   (s_axis_tdata),
        .end_of_text (s_axis_tlast),
        .push        (push)
    );

    assign first_w = push.digit_valid ? push.digit : push.summary;
    assign n_push  = 2'(push.digit_valid) + 2'(push.summary_valid);
    assign pop     = m_axis_tvalid && m_axis_tready;

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(n_push);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + (PTR_W+1)'(n_push) - (PTR_W+1)'(pop);

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            mem[wr_ptr_reg] <= first_w;
        if (n_push == 2'd2)
            mem[wr_ptr_reg + 1'b1] <= push.summary;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head          = mem[rd_ptr_reg];
    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tlast  = head.is_summary;
    assign m_axis_tdata  = {2'b00, head.parse_error, head.decimal_order,
                            head.digit_count, head.negative, head.digit_value};

endmodule

### rtl/dftp_checker.sv
module dftp_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic [dftp_pkg::CHAR_W-1:0]  s_axis_tdata,
    input logic                         s_axis_tlast,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [dftp_pkg::OUT_W-1:0]   m_axis_tdata,
    input logic                         m_axis_tlast
);
    import dftp_pkg::*;

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    a_digit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |->
            m_axis_tdata[3:0] <= 4'd9 && m_axis_tdata[31:4] == 28'd0)
        else $error("malformed digit word");

    a_summary: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |->
            m_axis_tdata[3:0] == 4'd0 && m_axis_tdata[31:30] == 2'd0
            && m_axis_tdata[10:5] <= 6'd63)
        else $error("malformed summary word");

    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast && m_axis_tdata[29] |->
            m_axis_tdata[28:4] == 25'd0)
        else $error("error summary carries data");

    a_term: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tdata == CH_LF || s_axis_tlast)
            |=> m_axis_tvalid)
        else $error("end of number gave no output");

endmodule

bind decimal_float_text_parser dftp_checker u_dftp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
